FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/tmce_pkg.sv
`timescale 1ns / 1ps

package tmce_pkg;

   // Default geometry.
   localparam int unsigned DefColumns     = 80;
   localparam int unsigned DefRows        = 25;
   localparam int unsigned DefMemoryWords = 8192;

   // Widths fixed by the command format.
   localparam int unsigned AddrW = 13;
   localparam int unsigned DataW = 16;
   localparam int unsigned LenW  = 14;
   localparam int unsigned ColW  = 7;
   localparam int unsigned RowW  = 5;
   localparam int unsigned MaxRes = 6;
   localparam int unsigned CntW  = 3;

   // Register reset values.
   localparam logic [7:0]       AttrReset  = 8'h07;
   localparam logic [DataW-1:0] BlankReset = 16'h0720;

   // Register indexes.
   localparam logic CSR_CHAR_ATTR  = 1'b0;
   localparam logic CSR_BLANK_WORD = 1'b1;

   // Operations.
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Control bytes.
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_ENQ = 8'h05;
   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_VT  = 8'h0B;
   localparam logic [7:0] CH_FF  = 8'h0C;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_DEL = 8'h7F;

   typedef enum logic [2:0] {
      KIND_WRITE     = 3'd0,
      KIND_FILL      = 3'd1,
      KIND_COPY      = 3'd2,
      KIND_SET_START = 3'd3,
      KIND_SET_CURSOR = 3'd4,
      KIND_BEEP      = 3'd5
   } kind_type;

   typedef struct packed {
      logic [AddrW-1:0] source;
      logic [LenW-1:0]  length;
      logic [DataW-1:0] data;
      logic [AddrW-1:0] address;
      kind_type         kind;
   } res_type;

   function automatic res_type mk_res(kind_type k, logic [AddrW-1:0] a,
                                      logic [DataW-1:0] d, logic [LenW-1:0] l,
                                      logic [AddrW-1:0] s);
      res_type r;
      r.kind    = k;
      r.address = a;
      r.data    = d;
      r.length  = l;
      r.source  = s;
      return r;
   endfunction

endpackage

FILE: src/text_mode_console_engine.sv
`timescale 1ns / 1ps
// Text console command engine.
// req_*: one beat per input item; tdata is the character byte, tuser the
//   operation (0 process byte, 1 clear console), tlast marks the last byte
//   of a buffer and asks for a cursor update after it.
// rsp_*: display commands; tuser is the command kind, tdata carries
//   address, data, length and source, tlast flags the final command of an item.
// csr_*: register writes (0 character attribute, 1 blank word), always ready,
//   to be issued only while the engine is idle.
// Latency: the commands of an item appear from the cycle after its beat.
// Throughput: one item per cycle while each item gives at most one command and rsp_tready stays high.
//   An item giving more than one command (up to six: print, wrap, copy-down
//   scroll and cursor update) holds req_tready low until its last command is
//   being taken, as the six-entry command buffer drains one beat per cycle.
// A stalled rsp_tready holds the current command and back-pressures
//   req_tready for as long as any command is waiting.
// Reset (synchronous): screen position, cursor, skip flag and the buffer
//   clear; registers return to attribute 0x07 and blank word 0x0720.
`include "assert_macros.svh"

module text_mode_console_engine #(
   parameter int unsigned COLUMNS      = tmce_pkg::DefColumns,
   parameter int unsigned ROWS         = tmce_pkg::DefRows,
   parameter int unsigned MEMORY_WORDS = tmce_pkg::DefMemoryWords
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tuser,   // [0] operation
   input  logic        req_tlast,   // end_of_buffer
   // display commands
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [12:0] address, [28:13] data,
                                    // [42:29] length, [55:43] source
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,   // last
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned AW = tmce_pkg::AddrW;
   localparam int unsigned ScreenWords = COLUMNS * ROWS;
   localparam logic [AW-1:0] ColStep    = AW'(COLUMNS);
   localparam logic [AW-1:0] ScreenStep = AW'(ScreenWords);
   // scroll needs a copy-down when start + screen + one row reaches this
   localparam logic [AW+1:0] ScrollLimit = (AW+2)'(MEMORY_WORDS);
   localparam logic [AW+1:0] ScrollSpan  = (AW+2)'(ScreenWords + COLUMNS);

   // configuration
   logic [7:0]  attr_ff;
   logic [15:0] blank_ff;

   // console state
   logic [AW-1:0]                 start_ff, start_in;
   logic [AW-1:0]                 wpos_ff, wpos_in;
   logic [tmce_pkg::ColW-1:0]     col_ff, col_in;
   logic [tmce_pkg::RowW-1:0]     row_ff, row_in;
   logic                          skip_ff, skip_in;

   // command buffer: entry 0 is on the rsp port
   tmce_pkg::res_type              buf_ff [tmce_pkg::MaxRes];
   logic [tmce_pkg::CntW-1:0]      cnt_ff;
   tmce_pkg::res_type              gen_res [tmce_pkg::MaxRes];
   logic [tmce_pkg::CntW-1:0]      gen_cnt;

   logic req_acc, rsp_acc;
   logic do_scroll, do_feed, do_cr;
   logic [tmce_pkg::ColW:0] col_inc;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff == '0) || ((cnt_ff == tmce_pkg::CntW'(1)) && rsp_tready);
   assign req_acc    = req_tvalid && req_tready;

   assign rsp_tuser = buf_ff[0].kind;
   assign rsp_tdata = {buf_ff[0].source, buf_ff[0].length, buf_ff[0].data,
                       buf_ff[0].address};
   assign rsp_tlast = (cnt_ff == tmce_pkg::CntW'(1));

   // One pass over the item: next state and the list of commands it yields.
   always_comb begin
      logic [tmce_pkg::CntW-1:0] n;
      n        = '0;
      start_in = start_ff;
      wpos_in  = wpos_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      skip_in  = skip_ff;
      do_scroll = 1'b0;
      do_feed   = 1'b0;
      do_cr     = 1'b0;
      col_inc   = {1'b0, col_ff} + 1'b1;
      for (int i = 0; i < tmce_pkg::MaxRes; i++) begin
         gen_res[i] = '0;
      end

      if (req_tuser == tmce_pkg::OP_CLEAR) begin
         start_in = '0;
         wpos_in  = '0;
         col_in   = '0;
         row_in   = '0;
         skip_in  = 1'b0;
         gen_res[0] = tmce_pkg::mk_res(tmce_pkg::KIND_SET_START, '0, '0, '0, '0);
         gen_res[1] = tmce_pkg::mk_res(tmce_pkg::KIND_SET_CURSOR, '0, '0, '0, '0);
         gen_res[2] = tmce_pkg::mk_res(tmce_pkg::KIND_FILL, '0, blank_ff,
                                       tmce_pkg::LenW'(MEMORY_WORDS), '0);
         n = tmce_pkg::CntW'(3);
      end else begin
         if (!skip_ff) begin
            case (req_tdata)
               tmce_pkg::CH_NUL: begin
                  skip_in = 1'b1;
               end
               tmce_pkg::CH_ENQ, tmce_pkg::CH_TAB, tmce_pkg::CH_VT: begin
               end
               tmce_pkg::CH_BEL: begin
                  gen_res[n] = tmce_pkg::mk_res(tmce_pkg::KIND_BEEP, '0, '0, '0, '0);
                  n = n + 1'b1;
               end
               tmce_pkg::CH_BS: begin
                  if (col_ff != '0) begin
                     col_in  = col_ff - 1'b1;
                     wpos_in = wpos_ff - 1'b1;
                     gen_res[n] = tmce_pkg::mk_res(tmce_pkg::KIND_WRITE, wpos_in,
                                                   blank_ff, '0, '0);
                     n = n + 1'b1;
                  end else if (row_ff != '0 && wpos_ff != start_ff) begin
                     col_in  = tmce_pkg::ColW'(COLUMNS - 1);
                     row_in  = row_ff - 1'b1;
                     wpos_in = wpos_ff - 1'b1;
                     gen_res[n] = tmce_pkg::mk_res(tmce_pkg::KIND_WRITE, wpos_in,
                                                   blank_ff, '0, '0);
                     n = n + 1'b1;
                  end
               end
               tmce_pkg::CH_LF, tmce_pkg::CH_FF: begin
                  do_feed = 1'b1;
                  do_cr   = (req_tdata == tmce_pkg::CH_LF);
                  if ({1'b0, row_ff} + 1'b1 >= (tmce_pkg::RowW+1)'(ROWS)) begin
                     do_scroll = 1'b1;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
               tmce_pkg::CH_CR: begin
                  do_cr = 1'b1;
               end
               tmce_pkg::CH_DEL: begin
                  gen_res[n] = tmce_pkg::mk_res(tmce_pkg::KIND_WRITE, wpos_ff,
                                                blank_ff, '0, '0);
                  n = n + 1'b1;
               end
               default: begin
                  gen_res[n] = tmce_pkg::mk_res(tmce_pkg::KIND_WRITE, wpos_ff,
                                                {attr_ff, req_tdata}, '0, '0);
                  n = n + 1'b1;
                  wpos_in = wpos_ff + 1'b1;
                  if (col_inc >= (tmce_pkg::ColW+1)'(COLUMNS)) begin
                     col_in = tmce_pkg::ColW'(col_inc - (tmce_pkg::ColW+1)'(COLUMNS));
                     if ({1'b0, row_ff} + 1'b1 >= (tmce_pkg::RowW+1)'(ROWS)) begin
                        do_scroll = 1'b1;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_inc[tmce_pkg::ColW-1:0];
                  end
               end
            endcase
         end

         // scroll by one row, moving the screen to the base first if needed
         if (do_scroll) begin
            if ({2'b00, start_ff} + ScrollSpan >= ScrollLimit) begin
               gen_res[n] = tmce_pkg::mk_res(tmce_pkg::KIND_COPY, '0, '0,
                                             tmce_pkg::LenW'(ScreenWords), start_ff);
               n = n + 1'b1;
               wpos_in  = wpos_in - start_ff;
               start_in = '0;
               gen_res[n] = tmce_pkg::mk_res(tmce_pkg::KIND_SET_CURSOR, '0,
                                             tmce_pkg::DataW'(wpos_in), '0, '0);
               n = n + 1'b1;
            end
            gen_res[n] = tmce_pkg::mk_res(tmce_pkg::KIND_FILL, start_in + ScreenStep,
                                          blank_ff, tmce_pkg::LenW'(COLUMNS), '0);
            n = n + 1'b1;
            start_in = start_in + ColStep;
            gen_res[n] = tmce_pkg::mk_res(tmce_pkg::KIND_SET_START, '0,
                                          tmce_pkg::DataW'(start_in), '0, '0);
            n = n + 1'b1;
         end

         if (do_feed) begin
            wpos_in = wpos_in + ColStep;
         end
         if (do_cr) begin
            wpos_in = wpos_in - AW'(col_in);
            col_in  = '0;
         end

         if (req_tlast) begin
            gen_res[n] = tmce_pkg::mk_res(tmce_pkg::KIND_SET_CURSOR, '0,
                                          tmce_pkg::DataW'(wpos_in), '0, '0);
            n = n + 1'b1;
            skip_in = 1'b0;
         end
      end
      gen_cnt = n;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff  <= tmce_pkg::AttrReset;
         blank_ff <= tmce_pkg::BlankReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tmce_pkg::CSR_CHAR_ATTR:  attr_ff  <= csr_data[7:0];
            tmce_pkg::CSR_BLANK_WORD: blank_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // console state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         wpos_ff  <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         skip_ff  <= 1'b0;
      end else if (req_acc) begin
         start_ff <= start_in;
         wpos_ff  <= wpos_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         skip_ff  <= skip_in;
      end
   end

   // buffer fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (req_acc) begin
         cnt_ff <= gen_cnt;
      end else if (rsp_acc) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // buffer payload: load a fresh list, or step down one beat
   always_ff @(posedge clock) begin
      if (req_acc) begin
         for (int i = 0; i < tmce_pkg::MaxRes; i++) begin
            buf_ff[i] <= gen_res[i];
         end
      end else if (rsp_acc) begin
         for (int i = 0; i < tmce_pkg::MaxRes - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
      end
   end

   // with a command pending, input is taken only when the buffer empties this cycle
   `ASSERT_IMP(a_ready_drain, clock, reset, req_tready && rsp_tvalid,
               rsp_tlast && rsp_tready)
   // a clear starts with a set-start command on the next cycle
   `ASSERT_NXT(a_clear_first, clock, reset, req_acc && (req_tuser == tmce_pkg::OP_CLEAR),
               rsp_tvalid && (rsp_tuser == tmce_pkg::KIND_SET_START))
   // an item that yields commands shows one straight away
   `ASSERT_NXT(a_gen_shows, clock, reset, req_acc && (gen_cnt != '0), rsp_tvalid)
   // cursor stays on the screen
   `ASSERT_IMP(a_pos_range, clock, reset, 1'b1,
               ({1'b0, col_ff} < (tmce_pkg::ColW+1)'(COLUMNS)) &&
               ({1'b0, row_ff} < (tmce_pkg::RowW+1)'(ROWS)))

endmodule

FILE: bench/tb_text_mode_console_engine.sv
`timescale 1ns / 1ps

module tb_text_mode_console_engine;

   // Geometry of the instance under test (package defaults).
   localparam int Cols        = tmce_pkg::DefColumns;
   localparam int Rows        = tmce_pkg::DefRows;
   localparam int MemWords    = tmce_pkg::DefMemoryWords;
   localparam int ScreenWords = Cols * Rows;

   // Cycles without any beat on any channel before the run is abandoned.
   localparam int WatchdogLimit = 2000;
   // Cycles allowed after the last awaited command before a register write.
   localparam int SettleCycles  = 4;
   // Cycles allowed at the end for stray commands to show up.
   localparam int TailCycles    = 20;

   typedef enum int {
      IDLE_NONE,   // both sides run flat out
      IDLE_SEND,   // sender inserts idles at random, each drawn at 56 percent odds
      IDLE_RECV,   // receiver stalls at random, each drawn at 56 percent odds
      IDLE_BOTH    // both, at 19 percent odds each
   } idle_mode_type;

   // Random phases: idling, register settings (-1 picks a random value),
   // item count, share of line feeds (percent) and whether clears occur.
   // Long stretches without clears and heavy on line feeds push the screen
   // start far enough up memory to force the copy back to the base.
   localparam idle_mode_type PhaseIdle[6] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV,
                                              IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
   localparam int PhaseAttr[6]   = '{0, 255, -1, 165, -1, 7};
   localparam int PhaseBlank[6]  = '{0, 65535, -1, 23130, -1, 1824};
   localparam int PhaseItems[6]  = '{70, 70, 80, 80, 80, 80};
   localparam int PhaseFeeds[6]  = '{15, 30, 50, 50, 50, 15};
   localparam bit PhaseClears[6] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   // One display command as seen on the result channel.
   typedef struct packed {
      tmce_pkg::kind_type         kind;
      logic [tmce_pkg::AddrW-1:0] address;
      logic [tmce_pkg::DataW-1:0] data;
      logic [tmce_pkg::LenW-1:0]  length;
      logic [tmce_pkg::AddrW-1:0] source;
      logic                       last;
   } disp_cmd_type;

   // One row of the directed table; typed_n > 0 means the commands for the
   // row are typed in by hand rather than worked out by the predictor.
   typedef struct packed {
      logic       op;
      logic [7:0] ch;
      logic       eob;
      logic [1:0] typed_n;
   } dir_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [55:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [15:0] csr_data   = '0;

   text_mode_console_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Console predictor: its own copy of registers and screen state.
   // ---------------------------------------------------------------------
   logic [7:0]                 attr_q    = tmce_pkg::AttrReset;
   logic [tmce_pkg::DataW-1:0] blank_q   = tmce_pkg::BlankReset;
   logic [tmce_pkg::AddrW-1:0] scr_start = '0;   // first word of the visible screen
   logic [tmce_pkg::AddrW-1:0] wr_pos    = '0;   // word the next glyph lands in
   logic [tmce_pkg::ColW-1:0]  col       = '0;
   logic [tmce_pkg::RowW-1:0]  cur_row   = '0;
   bit                         skip_rest = 1'b0; // NUL seen, drop bytes to end of buffer

   disp_cmd_type item_cmds[$];     // commands of the item being predicted
   disp_cmd_type awaited_cmds[$];  // commands still due on the result channel
   disp_cmd_type typed_cmds[$];    // hand-typed commands of the directed table
   dir_row_type  dir_rows[$];

   idle_mode_type idle_mode    = IDLE_NONE;
   int            errors       = 0;
   int            quiet_cycles = 0;

   task automatic issue(tmce_pkg::kind_type k, logic [tmce_pkg::AddrW-1:0] a,
                        logic [tmce_pkg::DataW-1:0] d, logic [tmce_pkg::LenW-1:0] l,
                        logic [tmce_pkg::AddrW-1:0] s);
      disp_cmd_type c;
      c.kind    = k;
      c.address = a;
      c.data    = d;
      c.length  = l;
      c.source  = s;
      c.last    = 1'b0;
      item_cmds.push_back(c);
   endtask

   // Scroll by one row; copy the screen down to the base first when the
   // blank row would reach the end of memory.
   task automatic scroll_screen;
      if (int'(scr_start) + ScreenWords + Cols >= MemWords) begin
         issue(tmce_pkg::KIND_COPY, '0, '0, tmce_pkg::LenW'(ScreenWords), scr_start);
         wr_pos    = wr_pos - scr_start;
         scr_start = '0;
         issue(tmce_pkg::KIND_SET_CURSOR, '0, tmce_pkg::DataW'(wr_pos), '0, '0);
      end
      issue(tmce_pkg::KIND_FILL, tmce_pkg::AddrW'(int'(scr_start) + ScreenWords),
            blank_q, tmce_pkg::LenW'(Cols), '0);
      scr_start = tmce_pkg::AddrW'(int'(scr_start) + Cols);
      issue(tmce_pkg::KIND_SET_START, '0, tmce_pkg::DataW'(scr_start), '0, '0);
   endtask

   task automatic next_row;
      if (int'(cur_row) + 1 >= Rows) scroll_screen();
      else cur_row++;
   endtask

   task automatic feed_line;
      next_row();
      wr_pos = wr_pos + tmce_pkg::AddrW'(Cols);
   endtask

   task automatic return_carriage;
      wr_pos = wr_pos - tmce_pkg::AddrW'(col);
      col    = '0;
   endtask

   // Backspace wraps to the end of the previous row, but never above row 0
   // nor past the screen start.
   task automatic back_space;
      if (col != '0) begin
         col--;
      end else begin
         if (cur_row == '0 || wr_pos == scr_start) return;
         col = tmce_pkg::ColW'(Cols - 1);
         cur_row--;
      end
      wr_pos = wr_pos - 1'b1;
      issue(tmce_pkg::KIND_WRITE, wr_pos, blank_q, '0, '0);
   endtask

   task automatic print_glyph(logic [7:0] ch);
      issue(tmce_pkg::KIND_WRITE, wr_pos, {attr_q, ch}, '0, '0);
      wr_pos = wr_pos + 1'b1;
      col++;
      if (int'(col) >= Cols) begin
         col = col - tmce_pkg::ColW'(Cols);
         next_row();
      end
   endtask

   // Work out every display command that one input item causes.
   task automatic render_item(logic op, logic [7:0] ch, logic eob);
      item_cmds.delete();
      if (op == tmce_pkg::OP_CLEAR) begin
         // clear ignores end of buffer and wipes the skip flag too
         scr_start = '0;
         wr_pos    = '0;
         col       = '0;
         cur_row   = '0;
         skip_rest = 1'b0;
         issue(tmce_pkg::KIND_SET_START, '0, '0, '0, '0);
         issue(tmce_pkg::KIND_SET_CURSOR, '0, '0, '0, '0);
         issue(tmce_pkg::KIND_FILL, '0, blank_q, tmce_pkg::LenW'(MemWords), '0);
      end else begin
         if (!skip_rest) begin
            case (ch)
               tmce_pkg::CH_NUL: skip_rest = 1'b1;
               tmce_pkg::CH_ENQ, tmce_pkg::CH_TAB, tmce_pkg::CH_VT: ;
               tmce_pkg::CH_BEL: issue(tmce_pkg::KIND_BEEP, '0, '0, '0, '0);
               tmce_pkg::CH_BS:  back_space();
               tmce_pkg::CH_LF: begin
                  feed_line();
                  return_carriage();
               end
               tmce_pkg::CH_FF:  feed_line();
               tmce_pkg::CH_CR:  return_carriage();
               tmce_pkg::CH_DEL: issue(tmce_pkg::KIND_WRITE, wr_pos, blank_q, '0, '0);
               default: print_glyph(ch);
            endcase
         end
         // end of buffer places the cursor even after a skipped byte
         if (eob) begin
            issue(tmce_pkg::KIND_SET_CURSOR, '0, tmce_pkg::DataW'(wr_pos), '0, '0);
            skip_rest = 1'b0;
         end
      end
      if (item_cmds.size() > 0) item_cmds[item_cmds.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Directed table helpers.
   // ---------------------------------------------------------------------
   task automatic add_row(logic op, logic [7:0] ch, logic eob, int typed_n);
      dir_row_type r;
      r.op      = op;
      r.ch      = ch;
      r.eob     = eob;
      r.typed_n = 2'(typed_n);
      dir_rows.push_back(r);
   endtask

   task automatic add_typed(tmce_pkg::kind_type k, int a, int d, int l, logic last);
      disp_cmd_type c;
      c.kind    = k;
      c.address = tmce_pkg::AddrW'(a);
      c.data    = tmce_pkg::DataW'(d);
      c.length  = tmce_pkg::LenW'(l);
      c.source  = '0;
      c.last    = last;
      typed_cmds.push_back(c);
   endtask

   // ---------------------------------------------------------------------
   // Drivers. Everything is driven at the falling edge; handshakes are
   // judged at the rising edge.
   // ---------------------------------------------------------------------

   // Presents one item and holds it until its beat. Leaves tvalid high so
   // the next item follows back to back unless the caller idles.
   task automatic send_item(logic op, logic [7:0] ch, logic eob, int typed_n);
      int send_pct;
      send_pct = (idle_mode == IDLE_SEND) ? 56 : (idle_mode == IDLE_BOTH) ? 19 : 0;
      while ($urandom_range(0, 99) < send_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= op;
      req_tlast  <= eob;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      render_item(op, ch, eob);
      if (typed_n > 0) begin
         // predictor still runs to keep its state, the typed values win
         repeat (typed_n) awaited_cmds.push_back(typed_cmds.pop_front());
      end else begin
         foreach (item_cmds[i]) awaited_cmds.push_back(item_cmds[i]);
      end
      @(negedge clock);
   endtask

   // Stop sending and wait until every awaited command has come out, then
   // idle for SettleCycles for items that produce nothing.
   task automatic settle_engine;
      req_tvalid <= 1'b0;
      while (awaited_cmds.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Register write; csr_valid is left high for a following write.
   task automatic csr_write(logic idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == tmce_pkg::CSR_CHAR_ATTR) attr_q = value[7:0];
      else blank_q = value;
      @(negedge clock);
   endtask

   // Random byte stream: mostly printable and arbitrary bytes, a chosen
   // share of line feeds, a sprinkling of control bytes and rare clears.
   task automatic random_item(int feed_pct, bit clears, output logic op,
                              output logic [7:0] ch, output logic eob);
      int pick;
      pick = $urandom_range(0, 99);
      op   = tmce_pkg::OP_BYTE;
      eob  = ($urandom_range(0, 7) == 0);
      ch   = 8'($urandom_range(0, 255));
      if (clears && $urandom_range(0, 59) == 0) begin
         op = tmce_pkg::OP_CLEAR;
      end else if (pick < feed_pct) begin
         ch = ($urandom_range(0, 3) == 0) ? tmce_pkg::CH_FF : tmce_pkg::CH_LF;
      end else if (pick < feed_pct + 14) begin
         case ($urandom_range(0, 9))
            0: ch = tmce_pkg::CH_NUL;
            1: ch = tmce_pkg::CH_ENQ;
            2: ch = tmce_pkg::CH_BEL;
            3, 4: ch = tmce_pkg::CH_BS;
            5: ch = tmce_pkg::CH_TAB;
            6: ch = tmce_pkg::CH_VT;
            7, 8: ch = tmce_pkg::CH_CR;
            default: ch = tmce_pkg::CH_DEL;
         endcase
      end
   endtask

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      case (idle_mode)
         IDLE_RECV: rsp_tready <= ($urandom_range(0, 99) >= 56);
         IDLE_BOTH: rsp_tready <= ($urandom_range(0, 99) >= 19);
         default:   rsp_tready <= 1'b1;
      endcase
   end

   // ---------------------------------------------------------------------
   // Result checker: each command beat against the oldest awaited one.
   // ---------------------------------------------------------------------
   function automatic string show_cmd(disp_cmd_type c);
      return $sformatf("kind %0d addr %0d data %h len %0d src %0d last %0b",
                       c.kind, c.address, c.data, c.length, c.source, c.last);
   endfunction

   always @(posedge clock) begin
      disp_cmd_type got;
      disp_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind    = tmce_pkg::kind_type'(rsp_tuser);
         got.address = rsp_tdata[12:0];
         got.data    = rsp_tdata[28:13];
         got.length  = rsp_tdata[42:29];
         got.source  = rsp_tdata[55:43];
         got.last    = rsp_tlast;
         if (awaited_cmds.size() == 0) begin
            errors++;
            $display("%0t: command beat with nothing awaited: %s", $time, show_cmd(got));
         end else begin
            want = awaited_cmds.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: command mismatch: expected %s, got %s",
                        $time, show_cmd(want), show_cmd(got));
            end
         end
      end
   end

   // Watchdog: any beat on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: no beat for %0d cycles, %0d commands outstanding",
                  $time, quiet_cycles, awaited_cmds.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------
   initial begin
      logic       op;
      logic [7:0] ch;
      logic       eob;
      int         attr_v;
      int         blank_v;

      // Directed table, reset register values in force.
      // clear straight after reset
      add_row(tmce_pkg::OP_CLEAR, tmce_pkg::CH_NUL, 1'b0, 3);
      add_typed(tmce_pkg::KIND_SET_START, 0, 0, 0, 1'b0);
      add_typed(tmce_pkg::KIND_SET_CURSOR, 0, 0, 0, 1'b0);
      add_typed(tmce_pkg::KIND_FILL, 0, tmce_pkg::BlankReset, MemWords, 1'b1);
      add_row(tmce_pkg::OP_BYTE, 8'h41, 1'b0, 1);              // plain glyph at the origin
      add_typed(tmce_pkg::KIND_WRITE, 0, 16'h0741, 0, 1'b1);
      add_row(tmce_pkg::OP_BYTE, 8'hFF, 1'b1, 2);              // top byte, end of buffer
      add_typed(tmce_pkg::KIND_WRITE, 1, 16'h07FF, 0, 1'b0);
      add_typed(tmce_pkg::KIND_SET_CURSOR, 0, 2, 0, 1'b1);
      add_row(tmce_pkg::OP_BYTE, 8'h01, 1'b0, 1);              // lowest printable code
      add_typed(tmce_pkg::KIND_WRITE, 2, 16'h0701, 0, 1'b1);
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_BEL, 1'b0, 1);
      add_typed(tmce_pkg::KIND_BEEP, 0, 0, 0, 1'b1);
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_ENQ, 1'b0, 0);   // ignored controls
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_TAB, 1'b0, 0);
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_VT, 1'b0, 0);
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_DEL, 1'b0, 1);   // erase in place
      add_typed(tmce_pkg::KIND_WRITE, 3, tmce_pkg::BlankReset, 0, 1'b1);
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_BS, 1'b0, 0);
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_CR, 1'b0, 0);
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_BS, 1'b0, 0);    // backspace stuck on row 0
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_LF, 1'b0, 0);
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_BS, 1'b0, 0);    // back to end of row above
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_FF, 1'b0, 0);
      add_row(tmce_pkg::OP_BYTE, 8'h80, 1'b1, 0);              // wraps the line, then cursor
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_NUL, 1'b0, 0);   // start skipping
      add_row(tmce_pkg::OP_BYTE, 8'h42, 1'b0, 0);
      // end of buffer on a skipped byte still places the cursor
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_LF, 1'b1, 0);
      add_row(tmce_pkg::OP_BYTE, tmce_pkg::CH_NUL, 1'b1, 0);
      add_row(tmce_pkg::OP_CLEAR, 8'hFF, 1'b1, 3);             // end of buffer ignored on clear
      add_typed(tmce_pkg::KIND_SET_START, 0, 0, 0, 1'b0);
      add_typed(tmce_pkg::KIND_SET_CURSOR, 0, 0, 0, 1'b0);
      add_typed(tmce_pkg::KIND_FILL, 0, tmce_pkg::BlankReset, MemWords, 1'b1);
      add_row(tmce_pkg::OP_BYTE, 8'h7E, 1'b1, 2);
      add_typed(tmce_pkg::KIND_WRITE, 0, 16'h077E, 0, 1'b0);
      add_typed(tmce_pkg::KIND_SET_CURSOR, 0, 1, 0, 1'b1);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].eob, dir_rows[i].typed_n);

      for (int p = 0; p < 6; p++) begin
         // registers only change with the engine idle
         settle_engine();
         attr_v  = (PhaseAttr[p] < 0) ? $urandom_range(0, 255) : PhaseAttr[p];
         blank_v = (PhaseBlank[p] < 0) ? $urandom_range(0, 65535) : PhaseBlank[p];
         // upper byte of an attribute write is don't-care, so make it noise
         csr_write(tmce_pkg::CSR_CHAR_ATTR, {8'($urandom_range(0, 255)), 8'(attr_v)});
         csr_write(tmce_pkg::CSR_BLANK_WORD, 16'(blank_v));
         csr_valid <= 1'b0;
         idle_mode = PhaseIdle[p];
         repeat (PhaseItems[p]) begin
            // now and then hold off until the command queue has drained
            if ($urandom_range(0, 39) == 0) settle_engine();
            random_item(PhaseFeeds[p], PhaseClears[p], op, ch, eob);
            send_item(op, ch, eob, 0);
         end
      end

      req_tvalid <= 1'b0;
      while (awaited_cmds.size() != 0) @(negedge clock);
      repeat (TailCycles) @(posedge clock);
      if (awaited_cmds.size() != 0) begin
         errors++;
         $display("%0t: %0d commands never arrived", $time, awaited_cmds.size());
      end
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: text_mode_console_engine.f
+incdir+src
src/tmce_pkg.sv
src/text_mode_console_engine.sv
bench/tb_text_mode_console_engine.sv
